// ----- sv/assert_macros.svh -----
// Assertion macros used by ppp_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PPP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ppp assertion failed");
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppp assertion failed");
`else
`define PPP_ASSERT(lbl, expr)
`define PPP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/ppp_pkg.sv -----
`timescale 1ns / 1ps
package ppp_pkg;
  localparam int COORD_W       = 32;
  localparam int COEF_W        = 32;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 51;
  localparam int PIX_W         = 12;
  localparam int DIM_W         = 13;
  localparam int REG_W         = 64;
  localparam int IDX_W         = 3;
  localparam int MAX_IMAGE_DIM = 4096;
  localparam int DIV_STAGES    = PIX_W;
  localparam int REM_W         = SUM_W - 1 + PIX_W;
  localparam int WSH_W         = SUM_W + PIX_W;
  localparam int MID_DEPTH     = 4;
  localparam int MID_PTR_W     = 2;
  localparam int MID_CNT_W     = 3;
  localparam int OUT_DEPTH     = 16;
  localparam int OUT_PTR_W     = 4;
  localparam int OUT_CNT_W     = 5;

  localparam logic [IDX_W-1:0] REG_ROW0_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_A = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_A = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_B = 3'd5;
  localparam logic [IDX_W-1:0] REG_IMG_W  = 3'd6;
  localparam logic [IDX_W-1:0] REG_IMG_H  = 3'd7;

  localparam logic [DIM_W-1:0] IMG_W_RESET = 13'd640;
  localparam logic [DIM_W-1:0] IMG_H_RESET = 13'd480;

  typedef enum logic [1:0] {
    ST_KEPT    = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
  } row_coef_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] n0;
    logic signed [SUM_W-1:0] n1;
    logic signed [SUM_W-1:0] w;
    logic                    zero;
  } mid_t;

  typedef struct packed {
    logic [MID_CNT_W-1:0] count;
    logic                 empty;
  } mid_stat_t;

  typedef struct packed {
    logic [REM_W-1:0] rem0;
    logic [REM_W-1:0] rem1;
    logic [PIX_W-1:0] q0;
    logic [PIX_W-1:0] q1;
    logic [SUM_W-2:0] w;
    status_t          st;
    logic             ok0;
    logic             ok1;
  } div_t;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    status_t          st;
  } res_t;

  // One restoring step: quotient bit k of both rows.
  function automatic div_t div_step(input div_t a, input logic [3:0] k);
    div_t             r;
    logic [REM_W-1:0] d;
    r = a;
    d = {{(REM_W-SUM_W+1){1'b0}}, a.w} << k;
    if (a.rem0 >= d) begin
      r.rem0 = a.rem0 - d;
      r.q0[k] = 1'b1;
    end
    if (a.rem1 >= d) begin
      r.rem1 = a.rem1 - d;
      r.q1[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : v;
  endfunction
endpackage

// ----- sv/ppp_front.sv -----
`timescale 1ns / 1ps
module ppp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic signed [ppp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [ppp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [ppp_pkg::COORD_W-1:0] pos_z,
  input  ppp_pkg::row_coef_t                coef [3],
  input  ppp_pkg::mid_stat_t                mid_stat,
  output logic                              full,
  output logic                              mid_push,
  output ppp_pkg::mid_t                     mid_data
);
  import ppp_pkg::*;

  logic                     v1, v2;
  logic                     zero1;
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [COEF_W-1:0] c3   [3];
  logic signed [SUM_W-1:0]  sums [3];
  logic [MID_CNT_W:0]       used;
  logic                     accept;

  assign used   = {1'b0, mid_stat.count} + (MID_CNT_W+1)'(v1) + (MID_CNT_W+1)'(v2);
  assign full   = used >= (MID_CNT_W+1)'(MID_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    zero1 <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
    for (int r = 0; r < 3; r++) begin
      prod[r][0] <= PROD_W'(coef[r].c0) * PROD_W'(pos_x);
      prod[r][1] <= PROD_W'(coef[r].c1) * PROD_W'(pos_y);
      prod[r][2] <= PROD_W'(coef[r].c2) * PROD_W'(pos_z);
      c3[r]      <= coef[r].c3;
    end
  end

  // stage 2: floor to Q16.16 and add offset
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sums[r] = SUM_W'((prod[r][0] >>> 16) + (prod[r][1] >>> 16)
                     + (prod[r][2] >>> 16) + PROD_W'(c3[r]));
    end
  end

  always_ff @(posedge clk) begin
    mid_data.n0   <= sums[0];
    mid_data.n1   <= sums[1];
    mid_data.w    <= sums[2];
    mid_data.zero <= zero1;
  end

  assign mid_push = v2;
endmodule

// ----- sv/ppp_queue.sv -----
`timescale 1ns / 1ps
module ppp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  ppp_pkg::mid_t      wr_data,
  input  logic               rd,
  output ppp_pkg::mid_t      head,
  output ppp_pkg::mid_stat_t stat
);
  import ppp_pkg::*;

  mid_t                 mem [MID_DEPTH];
  logic [MID_PTR_W-1:0] wp, rp;
  logic [MID_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + MID_CNT_W'(wr) - MID_CNT_W'(rd);
    end
  end

  assign head       = mem[rp];
  assign stat.count = cnt;
  assign stat.empty = (cnt == '0);
endmodule

// ----- sv/ppp_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ppp_pkg::mid_t                 mid_head,
  input  ppp_pkg::mid_stat_t            mid_stat,
  output logic                          mid_pop,
  input  logic [ppp_pkg::DIM_W-1:0]     dim_w,
  input  logic [ppp_pkg::DIM_W-1:0]     dim_h,
  input  logic                          pop,
  output logic                          empty,
  output logic [ppp_pkg::PIX_W-1:0]     col,
  output logic [ppp_pkg::PIX_W-1:0]     row,
  output ppp_pkg::status_t              st
);
  import ppp_pkg::*;

  div_t                 pipe [DIV_STAGES+1];
  logic                 vld  [DIV_STAGES+1];
  div_t                 cls;
  logic                 wpos;
  logic signed [WSH_W-1:0] wsh, n0x, n1x;
  res_t                 fin;
  logic                 keep;
  res_t                 oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owp, orp;
  logic [OUT_CNT_W-1:0] out_cnt, inflight;
  logic [OUT_CNT_W:0]   credit;
  logic                 out_pop;

  assign credit  = {1'b0, out_cnt} + {1'b0, inflight};
  assign mid_pop = !mid_stat.empty && (credit < (OUT_CNT_W+1)'(OUT_DEPTH));
  assign out_pop = pop && !empty;

  // classify: zero point, depth sign and quotient range 1..4095
  always_comb begin
    wpos = !mid_head.w[SUM_W-1] && (mid_head.w != '0);
    wsh  = {mid_head.w, {PIX_W{1'b0}}};
    n0x  = WSH_W'(mid_head.n0);
    n1x  = WSH_W'(mid_head.n1);
    cls.rem0 = REM_W'(mid_head.n0);
    cls.rem1 = REM_W'(mid_head.n1);
    cls.q0   = '0;
    cls.q1   = '0;
    cls.w    = mid_head.w[SUM_W-2:0];
    cls.ok0  = (mid_head.n0 >= mid_head.w) && (n0x < wsh);
    cls.ok1  = (mid_head.n1 >= mid_head.w) && (n1x < wsh);
    if (mid_head.zero) begin
      cls.st = ST_ZERO;
    end else if (!wpos) begin
      cls.st = ST_BEHIND;
    end else begin
      cls.st = ST_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= cls;
    for (int s = 1; s <= DIV_STAGES; s++) begin
      pipe[s] <= div_step(pipe[s-1], 4'(DIV_STAGES - s));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= mid_pop;
      for (int s = 1; s <= DIV_STAGES; s++) vld[s] <= vld[s-1];
    end
  end

  // bounds test against the clamped image size
  always_comb begin
    keep = pipe[DIV_STAGES].ok0 && pipe[DIV_STAGES].ok1
        && ({1'b0, pipe[DIV_STAGES].q0} < eff_dim(dim_w))
        && ({1'b0, pipe[DIV_STAGES].q1} < eff_dim(dim_h));
    fin.col = '0;
    fin.row = '0;
    fin.st  = pipe[DIV_STAGES].st;
    if (pipe[DIV_STAGES].st == ST_KEPT) begin
      if (keep) begin
        fin.col = pipe[DIV_STAGES].q0;
        fin.row = pipe[DIV_STAGES].q1;
      end else begin
        fin.st = ST_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld[DIV_STAGES]) begin
      oq[owp] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp      <= '0;
      orp      <= '0;
      out_cnt  <= '0;
      inflight <= '0;
    end else begin
      if (vld[DIV_STAGES]) owp <= owp + 1'b1;
      if (out_pop) orp <= orp + 1'b1;
      out_cnt  <= out_cnt + OUT_CNT_W'(vld[DIV_STAGES]) - OUT_CNT_W'(out_pop);
      inflight <= inflight + OUT_CNT_W'(mid_pop) - OUT_CNT_W'(vld[DIV_STAGES]);
    end
  end

  assign empty = (out_cnt == '0);
  assign col   = oq[orp].col;
  assign row   = oq[orp].row;
  assign st    = oq[orp].st;

  `PPP_ASSERT(a_credit_bound, credit <= (OUT_CNT_W+1)'(OUT_DEPTH))
  `PPP_ASSERT(a_kept_inside, empty || (st != ST_KEPT) || ((col != '0) && (row != '0)))
  `PPP_ASSERT_NEXT(a_pop_enters, mid_pop, vld[0])
endmodule

// ----- sv/pinhole_point_projector_unit.sv -----
`timescale 1ns / 1ps
// Pinhole point projector: each request carries one lidar point (pos_x, pos_y,
// pos_z, signed Q16.16) and yields one result: the floored pixel column and
// row from a 3x4 Q16.16 camera matrix, plus a status (0 kept, 1 behind camera,
// 2 outside image, 3 zero point). Column and row read zero unless kept; the
// bounds test is strict at zero and image sizes above 4096 are clamped.
// Throughput is one point per clock while pop keeps up. A request passes two
// multiply/add stages in the front, a 4-entry queue, then a classify stage
// and twelve restoring-division stages (one quotient bit each, shared by
// column and row) ahead of a 16-entry result queue. full rises when the
// 4-entry queue, counting the points still in the front stages, has no
// more room. Matrix and size registers are written through wr_en/wr_index/
// wr_data with no wait; write them only while the block is drained.
module pinhole_point_projector_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [ppp_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [ppp_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [ppp_pkg::COORD_W-1:0]  pos_z,
  output logic                                empty,
  input  logic                                pop,
  output logic [ppp_pkg::PIX_W-1:0]           pixel_col,
  output logic [ppp_pkg::PIX_W-1:0]           pixel_row,
  output logic [1:0]                          status,
  input  logic                                wr_en,
  input  logic [ppp_pkg::IDX_W-1:0]           wr_index,
  input  logic [ppp_pkg::REG_W-1:0]           wr_data
);
  import ppp_pkg::*;

  logic [REG_W-1:0] mat [6];
  logic [DIM_W-1:0] img_w, img_h;
  row_coef_t        coef [3];
  mid_t             mid_in, mid_head;
  mid_stat_t        mid_stat;
  logic             mid_push, mid_pop;
  status_t          st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) mat[i] <= '0;
      img_w <= IMG_W_RESET;
      img_h <= IMG_H_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROW0_A: mat[0] <= wr_data;
        REG_ROW0_B: mat[1] <= wr_data;
        REG_ROW1_A: mat[2] <= wr_data;
        REG_ROW1_B: mat[3] <= wr_data;
        REG_ROW2_A: mat[4] <= wr_data;
        REG_ROW2_B: mat[5] <= wr_data;
        REG_IMG_W:  img_w  <= wr_data[DIM_W-1:0];
        REG_IMG_H:  img_h  <= wr_data[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // coefficient 0/2 in the low half of each pair, 1/3 in the high half
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r].c0 = mat[2*r][31:0];
      coef[r].c1 = mat[2*r][63:32];
      coef[r].c2 = mat[2*r+1][31:0];
      coef[r].c3 = mat[2*r+1][63:32];
    end
  end

  ppp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .coef     (coef),
    .mid_stat (mid_stat),
    .full     (full),
    .mid_push (mid_push),
    .mid_data (mid_in)
  );

  ppp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (mid_push),
    .wr_data (mid_in),
    .rd      (mid_pop),
    .head    (mid_head),
    .stat    (mid_stat)
  );

  ppp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_head (mid_head),
    .mid_stat (mid_stat),
    .mid_pop  (mid_pop),
    .dim_w    (img_w),
    .dim_h    (img_h),
    .pop      (pop),
    .empty    (empty),
    .col      (pixel_col),
    .row      (pixel_row),
    .st       (st)
  );

  assign status = st;
endmodule

// ----- test/ppp_result_checker.sv -----
`timescale 1ns / 1ps
// Watches the request, result and register-write ports of the projector.
// Keeps its own copy of the registers, predicts one result per accepted
// point and compares each popped result with the oldest prediction.
module ppp_result_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               full,
  input  logic signed [ppp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [ppp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [ppp_pkg::COORD_W-1:0] pos_z,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [ppp_pkg::PIX_W-1:0]          pixel_col,
  input  logic [ppp_pkg::PIX_W-1:0]          pixel_row,
  input  logic [1:0]                         status,
  input  logic                               wr_en,
  input  logic [ppp_pkg::IDX_W-1:0]          wr_index,
  input  logic [ppp_pkg::REG_W-1:0]          wr_data,
  output int                                 errors,
  output int                                 pending,
  output int                                 checked,
  output int                                 status_seen [4]
);
  import ppp_pkg::*;

  logic [REG_W-1:0] coef_regs [6];
  logic [DIM_W-1:0] img_w, img_h;
  res_t             expected_pixels [$];

  function automatic longint coef(input logic [REG_W-1:0] r, input int k);
    logic [31:0] c;
    c = k ? r[63:32] : r[31:0];
    return longint'($signed(c));
  endfunction

  function automatic longint row_total(input int r, input longint x, input longint y,
                                       input longint z);
    longint a, b, c;
    a = (coef(coef_regs[2*r], 0) * x) >>> 16;
    b = (coef(coef_regs[2*r], 1) * y) >>> 16;
    c = (coef(coef_regs[2*r+1], 0) * z) >>> 16;
    return a + b + c + coef(coef_regs[2*r+1], 1);
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_IMAGE_DIM) ? longint'(MAX_IMAGE_DIM) : longint'(v);
  endfunction

  function automatic res_t project_point(input longint x, input longint y, input longint z);
    res_t   r;
    longint w, u, v;
    r.col = '0;
    r.row = '0;
    if (x == 0 && y == 0 && z == 0) begin
      r.st = ST_ZERO;
    end else begin
      w = row_total(2, x, y, z);
      if (w <= 0) begin
        r.st = ST_BEHIND;
      end else begin
        u = floor_quot(row_total(0, x, y, z), w);
        v = floor_quot(row_total(1, x, y, z), w);
        if (u > 0 && u < clamp_dim(img_w) && v > 0 && v < clamp_dim(img_h)) begin
          r.st  = ST_KEPT;
          r.col = u[PIX_W-1:0];
          r.row = v[PIX_W-1:0];
        end else begin
          r.st = ST_OUTSIDE;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e;
    int   bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < 6; i++) coef_regs[i] <= '0;
      img_w   <= IMG_W_RESET;
      img_h   <= IMG_H_RESET;
      errors  <= 0;
      checked <= 0;
      for (int i = 0; i < 4; i++) status_seen[i] <= 0;
      expected_pixels.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_IMG_W: img_w <= wr_data[DIM_W-1:0];
          REG_IMG_H: img_h <= wr_data[DIM_W-1:0];
          default:   coef_regs[wr_index] <= wr_data;
        endcase
      end
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("result popped with none expected");
          bad++;
        end else begin
          e = expected_pixels.pop_front();
          if (pixel_col !== e.col) begin
            $error("pixel_col expected %0d got %0d", e.col, pixel_col);
            bad++;
          end
          if (pixel_row !== e.row) begin
            $error("pixel_row expected %0d got %0d", e.row, pixel_row);
            bad++;
          end
          if (status !== e.st) begin
            $error("status expected %0d got %0d", e.st, status);
            bad++;
          end
          status_seen[e.st] <= status_seen[e.st] + 1;
          checked <= checked + 1;
        end
      end
      if (bad != 0) errors <= errors + bad;
      if (push && !full)
        expected_pixels.push_back(project_point(pos_x, pos_y, pos_z));
    end
  end

  assign pending = expected_pixels.size();
endmodule

// ----- test/tb_pinhole_point_projector_unit.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the pinhole point projector. The checker beside
// the block does all prediction; this module only drives requests, pops
// results, programs the matrix and image size between phases and reports.
module tb_pinhole_point_projector_unit;
  import ppp_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [PIX_W-1:0]          pixel_col, pixel_row;
  logic [1:0]                status;
  logic                      wr_en = 1'b0;
  logic [IDX_W-1:0]          wr_index = '0;
  logic [REG_W-1:0]          wr_data = '0;
  int                        errors, pending, checked;
  int                        status_seen [4];
  int                        popped = 0;
  bit                        backlog_done = 0;

  always #5 clk = ~clk;

  pinhole_point_projector_unit uut (.*);

  ppp_result_checker chk (.*);

  // Sender gap: mostly none, sometimes short, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one point and hold it until the block takes it.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    int g;
    push  <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every request has produced its result.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    wr_en    <= 1'b0;
    @(posedge clk);
  endtask

  // Ideal pinhole camera: focal lengths and principal point in whole pixels.
  task automatic load_camera(input int fx, input int cx, input int fy, input int cy,
                             input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    write_reg(REG_ROW0_A, {32'd0, 32'(fx << 16)});
    write_reg(REG_ROW0_B, {32'd0, 32'(cx << 16)});
    write_reg(REG_ROW1_A, {32'(fy << 16), 32'd0});
    write_reg(REG_ROW1_B, {32'd0, 32'(cy << 16)});
    write_reg(REG_ROW2_A, 64'd0);
    write_reg(REG_ROW2_B, {32'd0, 32'h0001_0000});
    write_reg(REG_IMG_W, w);
    write_reg(REG_IMG_H, h);
  endtask

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
  endfunction

  // Mostly points in front of the camera within a plausible cone; the rest
  // is raw noise, zero points and points behind the camera.
  task automatic random_points(input int n);
    int          r;
    logic [31:0] z, span;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_point('0, '0, '0);
      end else if (r < 18) begin
        send_point($urandom, $urandom, $urandom);
      end else begin
        z    = $urandom_range(32'h0000_4000, 32'h0028_0000);
        span = z;
        if (r < 24) z = -z;
        send_point($urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, z);
      end
    end
  endtask

  // Receiver: pops with random stalls, and once holds off long enough that
  // the result queue fills and full pushes back on the sender.
  initial begin
    int hold, r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) popped++;
      if (rst) begin
        pop <= 1'b0;
      end else if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (!backlog_done && popped >= 600) begin
        backlog_done = 1;
        pop  <= 1'b0;
        hold = 400;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          pop <= 1'b1;
        end else if (r < 96) begin
          pop  <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          pop  <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset matrix is all zero: every nonzero point is behind the camera.
    send_point('0, '0, '0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    drain();

    // Directed: a 640x480 camera, focal 500, centre (320, 240).
    load_camera(500, 320, 500, 240, 640, 480);
    send_point('0, '0, '0);                                 // zero point
    send_point('0, '0, 32'h0001_0000);                      // centre pixel
    send_point(32'h0000_8000, 32'hFFFF_C000, 32'h0001_0000);// kept off-centre
    send_point('0, '0, 32'hFFFF_0000);                      // behind camera
    send_point(32'h7FFF_FFFF, '0, 32'h0000_0001);           // huge quotient
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);// far corner
    send_point(32'hFFFF_5C29, '0, 32'h0001_0000);           // column at zero edge
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);// column past width
    send_point(32'h0000_A3D7, 32'h0000_7AE1, 32'h0001_0000);// near far edges
    send_point(32'h0001_0000, '0, '0);                      // z zero, w zero
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    random_points(400);
    drain();

    // One-pixel image: nothing can be kept.
    load_camera(500, 320, 500, 240, 1, 1);
    random_points(200);
    drain();

    // Size registers at all ones are clamped to the largest image.
    load_camera(3000, 2040, 3000, 2040, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    random_points(350);
    drain();

    // Zero sizes.
    load_camera(500, 320, 500, 240, 0, 0);
    random_points(150);
    drain();

    // Exactly the largest size, then a small odd image.
    load_camera(2000, 4000, 2000, 100, 4096, 4096);
    random_points(300);
    drain();
    load_camera(40, 20, 40, 10, 37, 23);
    random_points(250);
    drain();

    // Fully random matrices with a depth row that is usually positive.
    repeat (3) begin
      for (int i = 0; i < 4; i++) write_reg(IDX_W'(i), {rand_coef(), rand_coef()});
      write_reg(REG_ROW2_A, {rand_coef(), rand_coef()});
      write_reg(REG_ROW2_B, {32'($urandom_range(0, 32'h0100_0000)), rand_coef()});
      write_reg(REG_IMG_W, 64'($urandom_range(1, 4096)));
      write_reg(REG_IMG_H, 64'($urandom_range(1, 4096)));
      random_points(120);
      drain();
    end

    $display("checked %0d results: %0d kept, %0d behind, %0d outside, %0d zero",
             checked, status_seen[ST_KEPT], status_seen[ST_BEHIND],
             status_seen[ST_OUTSIDE], status_seen[ST_ZERO]);
    $display("covered reset, clamped, zero, one-pixel and random matrix settings");
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule
